[rtl/pbc_pkg.sv]
// shared types and constants for the porta bigram cipher
package pbc_pkg;

    // field and storage widths
    localparam int SYM_W     = 8;
    localparam int NUM_W     = 10;
    localparam int IDX_W     = 5;
    localparam int LEN_W     = 6;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = $clog2(NUM_W);

    // last step of the shift-subtract divider
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    // register reset values
    localparam logic [WORD_W-1:0] ALPHA0_RST = 64'h4847_4645_4443_4241;
    localparam logic [WORD_W-1:0] ALPHA1_RST = 64'h504F_4E4D_4C4B_4A49;
    localparam logic [WORD_W-1:0] ALPHA2_RST = 64'h5857_5655_5453_5251;
    localparam logic [WORD_W-1:0] ALPHA3_RST = 64'h0000_0000_0000_5A59;
    localparam logic [LEN_W-1:0]  LEN_RST    = 6'd26;
    localparam logic [SYM_W-1:0]  PAD_RST    = 8'h5A;

    // item and result kinds
    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;
    localparam logic RES_NUMBER   = 1'b0;
    localparam logic RES_SYMBOL   = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA0 = 3'd0,
        CFG_ALPHA1 = 3'd1,
        CFG_ALPHA2 = 3'd2,
        CFG_ALPHA3 = 3'd3,
        CFG_LEN    = 3'd4,
        CFG_PAD    = 3'd5
    } t_cfg_idx;

endpackage

[rtl/porta_bigram_cipher.sv]
// porta bigram cipher: pair lookup scanner, shift-subtract divider and output register
//
// Encrypt items carry one symbol: the first of a pair is held and gives no
// result; the second (or a lone symbol flagged as message end, paired with the
// pad symbol) starts a scan of the alphabet, one position per cycle, and yields
// one number, row * length + column. Decrypt items carry one number that a
// radix-2 divider splits into quotient and remainder, one bit a cycle; two
// symbol words follow, quotient first. The length bounds the scan and the
// 10-bit number width sets the divider steps. One item is in work at a time
// and the input is ready again once the last word is taken. Configuration is
// taken every cycle and must only be written while the block is idle.
module porta_bigram_cipher
    import pbc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [SYM_W-1:0]     i_plain_symbol,
    input  logic [NUM_W-1:0]     i_cipher_number,
    input  logic                 i_message_end,
    // result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_result_kind,
    output logic [NUM_W-1:0]     o_number_out,
    output logic [SYM_W-1:0]     o_symbol_out,
    output logic                 o_run_last,
    output logic                 o_out_of_range,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ALPHABET_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PAIR,
        S_DIV,
        S_LOAD,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [WORD_W-1:0] r_alpha [NUM_WORDS];
    logic [LEN_W-1:0]  r_len;
    logic [SYM_W-1:0]  r_pad;

    // pair state
    logic [SYM_W-1:0]  r_held;
    logic              r_holding;

    // scan registers
    logic [SYM_W-1:0]  r_a;
    logic [SYM_W-1:0]  r_b;
    logic [IDX_W-1:0]  r_x;
    logic [IDX_W-1:0]  r_y;
    logic              r_fa;
    logic              r_fb;
    logic [IDX_W-1:0]  r_idx;

    // divider registers
    logic [NUM_W-1:0]  r_quo;
    logic [IDX_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;

    // output word register
    logic              r_o_valid;
    logic              r_res_kind;
    logic [NUM_W-1:0]  r_number;
    logic [SYM_W-1:0]  r_symbol;
    logic              r_last;
    logic              r_oor;

    logic [LEN_W-1:0]  w_len;
    logic [IDX_W-1:0]  w_lk_idx;
    logic [SYM_W-1:0]  w_lk_sym;
    logic              w_a_hit;
    logic              w_b_hit;
    logic              w_fa;
    logic              w_fb;
    logic              w_scan_done;
    logic [NUM_W-1:0]  w_prod;
    logic [NUM_W-1:0]  w_pair_num;
    logic [LEN_W-1:0]  w_trial;
    logic              w_qbit;
    logic [IDX_W-1:0]  w_rem_next;
    logic              w_q_over;

    // effective length, saturated to 1..ALPHABET_SIZE
    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_len;
        end
    end

    // single alphabet read port, address chosen by the sequencer
    always_comb begin
        case (r_state)
            S_SCAN:  w_lk_idx = r_idx;
            S_OUT:   w_lk_idx = r_rem;
            default: w_lk_idx = r_quo[IDX_W-1:0];
        endcase
    end
    assign w_lk_sym = r_alpha[w_lk_idx[IDX_W-1:3]][{w_lk_idx[2:0], 3'b000} +: SYM_W];

    // scan compare, most recent match wins until both are found
    assign w_a_hit     = (r_a == w_lk_sym);
    assign w_b_hit     = (r_b == w_lk_sym);
    assign w_fa        = r_fa | w_a_hit;
    assign w_fb        = r_fb | w_b_hit;
    assign w_scan_done = (w_fa && w_fb) || ({1'b0, r_idx} == (w_len - LEN_W'(1)));

    // pair number: row * length + column
    assign w_prod     = NUM_W'({{(NUM_W-IDX_W){1'b0}}, r_x} * {{(NUM_W-LEN_W){1'b0}}, w_len});
    assign w_pair_num = w_prod + {{(NUM_W-IDX_W){1'b0}}, r_y};

    // one restoring divider step
    assign w_trial    = {r_rem, r_quo[NUM_W-1]};
    assign w_qbit     = (w_trial >= w_len);
    assign w_rem_next = w_qbit ? IDX_W'(w_trial - w_len) : w_trial[IDX_W-1:0];
    assign w_q_over   = (r_quo >= {{(NUM_W-LEN_W){1'b0}}, w_len});

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_alpha[0] <= ALPHA0_RST;
            r_alpha[1] <= ALPHA1_RST;
            r_alpha[2] <= ALPHA2_RST;
            r_alpha[3] <= ALPHA3_RST;
            r_len      <= LEN_RST;
            r_pad      <= PAD_RST;
            r_held     <= '0;
            r_holding  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ALPHA0: r_alpha[0] <= i_cfg_data;
                    CFG_ALPHA1: r_alpha[1] <= i_cfg_data;
                    CFG_ALPHA2: r_alpha[2] <= i_cfg_data;
                    CFG_ALPHA3: r_alpha[3] <= i_cfg_data;
                    CFG_LEN:    r_len      <= i_cfg_data[LEN_W-1:0];
                    CFG_PAD:    r_pad      <= i_cfg_data[SYM_W-1:0];
                    default:    ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx <= '0;
                        r_fa  <= 1'b0;
                        r_fb  <= 1'b0;
                        r_x   <= '0;
                        r_y   <= '0;
                        if (i_kind == KIND_DECRYPT) begin
                            r_quo   <= i_cipher_number;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end else if (r_holding) begin
                            r_a       <= r_held;
                            r_b       <= i_plain_symbol;
                            r_held    <= '0;
                            r_holding <= 1'b0;
                            r_state   <= S_SCAN;
                        end else if (i_message_end) begin
                            r_a     <= i_plain_symbol;
                            r_b     <= r_pad;
                            r_state <= S_SCAN;
                        end else begin
                            r_held    <= i_plain_symbol;
                            r_holding <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_a_hit) begin
                        r_x <= r_idx;
                    end
                    if (w_b_hit) begin
                        r_y <= r_idx;
                    end
                    r_fa  <= w_fa;
                    r_fb  <= w_fb;
                    r_idx <= r_idx + IDX_W'(1);
                    if (w_scan_done) begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_o_valid  <= 1'b1;
                    r_res_kind <= RES_NUMBER;
                    r_number   <= w_pair_num;
                    r_symbol   <= '0;
                    r_last     <= 1'b1;
                    r_oor      <= 1'b0;
                    r_state    <= S_OUT;
                end
                S_DIV: begin
                    r_rem <= w_rem_next;
                    r_quo <= {r_quo[NUM_W-2:0], w_qbit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // quotient symbol word
                    r_o_valid  <= 1'b1;
                    r_res_kind <= RES_SYMBOL;
                    r_number   <= '0;
                    r_symbol   <= w_q_over ? '0 : w_lk_sym;
                    r_last     <= 1'b0;
                    r_oor      <= w_q_over;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (!r_last) begin
                            // remainder symbol word
                            r_symbol <= w_lk_sym;
                            r_oor    <= 1'b0;
                            r_last   <= 1'b1;
                        end else begin
                            r_o_valid <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_o_valid <= 1'b0;
                    r_state   <= S_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_o_valid;
    assign o_result_kind  = r_res_kind;
    assign o_number_out   = r_number;
    assign o_symbol_out   = r_symbol;
    assign o_run_last     = r_last;
    assign o_out_of_range = r_oor;

    // checks
    a_ready_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while a result word is pending");

    a_oor_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_symbol_out == '0 && o_result_kind == RES_SYMBOL
            && !o_run_last))
        else $error("out of range word with nonzero symbol or wrong kind");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_run_last) |=> (!o_valid && o_ready))
        else $error("word after the last word of a run");

    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_holding |-> (r_held == '0))
        else $error("held symbol not cleared while nothing is held");

endmodule
